// File: hdl/rdbg_pkg.sv
// Shared constants, codes and types of the rotary detent and button gesture core.
package rdbg_pkg;

    localparam int TIME_BITS     = 32;
    localparam int POS_BITS      = 32;
    localparam int DELTA_BITS    = 16;
    localparam int CPD_BITS      = 8;
    localparam int POLL_BITS     = 8;
    localparam int GAP_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int EV_KIND_BITS  = 3;

    // Signed remainder, remainder sum, working quotient, clamped quotient, pending sum.
    localparam int REM_BITS     = CPD_BITS + 1;
    localparam int RSUM_BITS    = CPD_BITS + 2;
    localparam int QW_BITS      = DELTA_BITS + 4;
    localparam int QF_BITS      = DELTA_BITS + 2;
    localparam int SUM_BITS     = DELTA_BITS + 3;
    localparam int DIV_CNT_BITS = $clog2(POS_BITS);

    localparam logic [QW_BITS-1:0]         Q_PRE_LIMIT = QW_BITS'(1) << (DELTA_BITS + 2);
    localparam logic signed [QW_BITS-1:0]  Q_ONE       = QW_BITS'(1);
    localparam logic signed [QW_BITS-1:0]  Q_MAX       = QW_BITS'(1) << DELTA_BITS;
    localparam logic signed [QW_BITS-1:0]  Q_MIN       = -(QW_BITS'(1) << DELTA_BITS);
    localparam logic signed [SUM_BITS-1:0] D_MAX       = (SUM_BITS'(1) << (DELTA_BITS - 1)) - 1;
    localparam logic signed [SUM_BITS-1:0] D_MIN       = -(SUM_BITS'(1) << (DELTA_BITS - 1));
    localparam logic signed [DELTA_BITS-1:0] EV_VAL_ONE  = DELTA_BITS'(1);
    localparam logic signed [DELTA_BITS-1:0] EV_VAL_ZERO = '0;

    localparam logic KIND_START = 1'b0;

    localparam logic [CPD_BITS-1:0]  CPD_RST        = 8'd1;
    localparam logic [POLL_BITS-1:0] POLL_RST       = 8'd2;
    localparam logic                 CW_RST         = 1'b1;
    localparam logic [GAP_BITS-1:0]  BOUNCE_RST     = 16'd120;
    localparam logic [GAP_BITS-1:0]  GUARD_RST      = 16'd25;
    localparam logic [GAP_BITS-1:0]  HOLD_RST       = 16'd500;
    localparam logic [GAP_BITS-1:0]  DBL_RST        = 16'd400;
    localparam logic [GAP_BITS-1:0]  MIN_CLICK_RST  = 16'd50;

    typedef enum logic [EV_KIND_BITS-1:0] {
        EV_SPEED        = 3'd0,
        EV_HOLD         = 3'd1,
        EV_HOLD_RELEASE = 3'd2,
        EV_DOUBLE_CLICK = 3'd3,
        EV_CLICK        = 3'd4
    } t_event_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COUNTS_PER_DETENT = 3'd0,
        CFG_POLL_INTERVAL     = 3'd1,
        CFG_CLOCKWISE_INC     = 3'd2,
        CFG_BOUNCE_FILTER     = 3'd3,
        CFG_PRE_PRESS_GUARD   = 3'd4,
        CFG_HOLD_THRESHOLD    = 3'd5,
        CFG_DOUBLE_CLICK_WIN  = 3'd6,
        CFG_MIN_CLICK         = 3'd7
    } t_cfg_index;

endpackage

// File: hdl/rdbg_in_if.sv
// Input channel: start and poll transactions.
interface rdbg_in_if import rdbg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [TIME_BITS-1:0]       time_ms;
    logic signed [POS_BITS-1:0] raw_position;
    logic                       button_pressed;

    modport source (output valid, output kind, output time_ms, output raw_position,
                    output button_pressed, input ready);
    modport sink   (input valid, input kind, input time_ms, input raw_position,
                    input button_pressed, output ready);
endinterface

// File: hdl/rdbg_out_if.sv
// Output channel: gesture and rotation event transactions.
interface rdbg_out_if import rdbg_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [EV_KIND_BITS-1:0]      event_kind;
    logic signed [DELTA_BITS-1:0] event_value;
    logic [TIME_BITS-1:0]         event_time;
    logic                         last;

    modport source (output valid, output event_kind, output event_value, output event_time,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input event_value, input event_time,
                    input last, output ready);
endinterface

// File: hdl/rdbg_div.sv
// Restoring serial divider: unsigned position magnitude by an 8-bit divisor, one bit a cycle.
module rdbg_div import rdbg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [POS_BITS-1:0] i_dividend,
    input  logic [CPD_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [POS_BITS-1:0] o_quot,
    output logic [CPD_BITS-1:0] o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [POS_BITS-1:0]     r_quot;
    logic [CPD_BITS-1:0]     r_rem;
    logic [CPD_BITS-1:0]     r_divisor;

    logic [CPD_BITS:0] trial;
    logic [CPD_BITS:0] trial_sub;
    logic              fits;

    assign trial     = {r_rem, r_quot[POS_BITS-1]};
    assign fits      = trial >= {1'b0, r_divisor};
    assign trial_sub = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= DIV_CNT_BITS'(POS_BITS - 1);
                r_quot    <= i_dividend;
                r_rem     <= '0;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                // shift one dividend bit into the partial remainder
                r_rem  <= fits ? trial_sub[CPD_BITS-1:0] : trial[CPD_BITS-1:0];
                r_quot <= {r_quot[POS_BITS-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: hdl/rotary_detent_and_button_gestures_core.sv
// Rotary encoder detent and push-button gesture core: top level.
// A start transaction produces nothing; a poll that arrives before start or before
// the poll interval has elapsed is dropped. A poll with no encoder motion runs a
// sequence of time compares through one shared subtract-and-compare unit; a poll with
// motion adds two passes of the 32-step serial divider (detents, then remainder carry).
// Results, at most two per poll, then leave one per cycle while the output side takes
// them, and the next input transaction is taken only after the last result has gone.
module rotary_detent_and_button_gestures_core import rdbg_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    rdbg_in_if.sink                  i_in,
    rdbg_out_if.source               o_out
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_POLL   = 17'h00002,
        S_BOUNCE = 17'h00004,
        S_DIV1   = 17'h00008,
        S_DIV2S  = 17'h00010,
        S_DIV2   = 17'h00020,
        S_FIX    = 17'h00040,
        S_CLAMP  = 17'h00080,
        S_PEND   = 17'h00100,
        S_GUARD  = 17'h00200,
        S_PRESS  = 17'h00400,
        S_HOLD   = 17'h00800,
        S_MINC   = 17'h01000,
        S_DBL    = 17'h02000,
        S_REL    = 17'h04000,
        S_CLICK  = 17'h08000,
        S_EMIT   = 17'h10000
    } t_state;

    // configuration
    logic [CPD_BITS-1:0]  r_cpd;
    logic [POLL_BITS-1:0] r_poll_ms;
    logic                 r_cw;
    logic [GAP_BITS-1:0]  r_bounce_ms;
    logic [GAP_BITS-1:0]  r_guard_ms;
    logic [GAP_BITS-1:0]  r_hold_ms;
    logic [GAP_BITS-1:0]  r_dbl_ms;
    logic [GAP_BITS-1:0]  r_min_click_ms;

    // architectural state
    t_state                       r_state;
    logic                         r_ready;
    logic [POS_BITS-1:0]          r_prev_pos;
    logic signed [REM_BITS-1:0]   r_cnt_rem;
    logic signed [DELTA_BITS-1:0] r_pending;
    logic [TIME_BITS-1:0]         r_pending_since;
    logic [TIME_BITS-1:0]         r_last_poll;
    logic [TIME_BITS-1:0]         r_last_button;
    logic [TIME_BITS-1:0]         r_press_start;
    logic [TIME_BITS-1:0]         r_first_click;
    logic                         r_was_down;
    logic                         r_hold_fired;
    logic                         r_awaiting;

    // per-poll working registers
    logic [TIME_BITS-1:0]         r_now;
    logic [POS_BITS-1:0]          r_pos;
    logic                         r_pressed;
    logic [POS_BITS-1:0]          r_delta;
    logic signed [QW_BITS-1:0]    r_q;
    logic signed [RSUM_BITS-1:0]  r_rsum;
    logic signed [REM_BITS-1:0]   r_rs;
    logic signed [QF_BITS-1:0]    r_qf;
    logic                         r_bounce_ok;
    logic                         r_hold_ge;
    logic                         r_min_ge;
    logic                         r_dbl_lt;
    t_event_kind                  r_ev_kind [2];
    logic signed [DELTA_BITS-1:0] r_ev_val [2];
    logic [1:0]                   r_n;
    logic                         r_idx;

    logic [CPD_BITS-1:0] cpd_eff;
    logic                in_fire;
    logic                out_fire;
    logic                out_last;

    assign cpd_eff  = (r_cpd == '0) ? CPD_BITS'(1) : r_cpd;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign out_last = ({1'b0, r_idx} + 2'd1) == r_n;

    // ---------------- shared time compare unit ----------------
    logic [TIME_BITS-1:0] cmp_x;
    logic [GAP_BITS-1:0]  cmp_y;
    logic [TIME_BITS-1:0] cmp_diff;
    logic                 cmp_ge;
    logic                 cmp_gt;

    always_comb begin
        case (r_state)
            S_POLL: begin
                cmp_x = r_last_poll;
                cmp_y = GAP_BITS'(r_poll_ms);
            end
            S_BOUNCE: begin
                cmp_x = r_last_button;
                cmp_y = r_bounce_ms;
            end
            S_GUARD: begin
                cmp_x = r_pending_since;
                cmp_y = r_guard_ms;
            end
            S_HOLD: begin
                cmp_x = r_press_start;
                cmp_y = r_hold_ms;
            end
            S_MINC: begin
                cmp_x = r_press_start;
                cmp_y = r_min_click_ms;
            end
            S_DBL, S_CLICK: begin
                cmp_x = r_first_click;
                cmp_y = r_dbl_ms;
            end
            default: begin
                cmp_x = '0;
                cmp_y = '0;
            end
        endcase
    end

    assign cmp_diff = r_now - cmp_x;
    assign cmp_ge   = cmp_diff >= TIME_BITS'(cmp_y);
    assign cmp_gt   = cmp_diff > TIME_BITS'(cmp_y);

    // ---------------- serial divider ----------------
    logic                 delta_neg;
    logic [POS_BITS-1:0]  delta_mag;
    logic                 rsum_neg;
    logic [RSUM_BITS-1:0] rsum_mag;
    logic                 div_start;
    logic [POS_BITS-1:0]  div_dividend;
    logic                 div_done;
    logic [POS_BITS-1:0]  div_quot;
    logic [CPD_BITS-1:0]  div_rem;

    assign delta_neg    = r_delta[POS_BITS-1];
    assign delta_mag    = delta_neg ? (-r_delta) : r_delta;
    assign rsum_neg     = r_rsum[RSUM_BITS-1];
    assign rsum_mag     = rsum_neg ? RSUM_BITS'(-r_rsum) : RSUM_BITS'(r_rsum);
    assign div_start    = ((r_state == S_BOUNCE) && (r_delta != '0)) || (r_state == S_DIV2S);
    assign div_dividend = (r_state == S_DIV2S) ? POS_BITS'(rsum_mag) : delta_mag;

    rdbg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (cpd_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ---------------- quotient and remainder arithmetic ----------------
    logic [QW_BITS-1:0]          q0_mag;
    logic signed [QW_BITS-1:0]   q0_s;
    logic signed [REM_BITS-1:0]  rem_ext;
    logic signed [REM_BITS-1:0]  r0_s;
    logic signed [RSUM_BITS-1:0] rsum_new;
    logic signed [QW_BITS-1:0]   q1_s;
    logic signed [QW_BITS-1:0]   qs_new;
    logic signed [REM_BITS-1:0]  rs_new;
    logic signed [RSUM_BITS-1:0] cpd_s;
    logic signed [RSUM_BITS-1:0] rs_w;
    logic                        q_pos;
    logic                        q_neg;
    logic                        rs_pos;
    logic                        rs_neg;
    logic signed [QW_BITS-1:0]   qc;
    logic signed [QF_BITS-1:0]   qf;
    logic signed [SUM_BITS-1:0]  pend_sum;
    logic signed [SUM_BITS-1:0]  pend_sat;

    // large quotients only feed the final clamp, so cap them early
    assign q0_mag   = (|div_quot[POS_BITS-1:DELTA_BITS+2]) ? Q_PRE_LIMIT
                                                           : QW_BITS'(div_quot[DELTA_BITS+1:0]);
    assign q0_s     = delta_neg ? -$signed(q0_mag) : $signed(q0_mag);
    assign rem_ext  = $signed({1'b0, div_rem});
    assign r0_s     = delta_neg ? -rem_ext : rem_ext;
    assign rsum_new = RSUM_BITS'(r_cnt_rem) + RSUM_BITS'(r0_s);
    assign q1_s     = rsum_neg ? -$signed(QW_BITS'(div_quot[RSUM_BITS-1:0]))
                               : $signed(QW_BITS'(div_quot[RSUM_BITS-1:0]));
    assign qs_new   = r_q + q1_s;
    assign rs_new   = rsum_neg ? -rem_ext : rem_ext;

    assign cpd_s  = $signed({2'b00, cpd_eff});
    assign rs_w   = RSUM_BITS'(r_rs);
    assign q_neg  = r_q[QW_BITS-1];
    assign q_pos  = !q_neg && (r_q != '0);
    assign rs_neg = r_rs[REM_BITS-1];
    assign rs_pos = !rs_neg && (r_rs != '0);

    assign qc       = (r_q > Q_MAX) ? Q_MAX : ((r_q < Q_MIN) ? Q_MIN : r_q);
    assign qf       = QF_BITS'(qc);
    assign pend_sum = SUM_BITS'(r_pending) + SUM_BITS'(r_qf);
    assign pend_sat = (pend_sum > D_MAX) ? D_MAX : ((pend_sum < D_MIN) ? D_MIN : pend_sum);

    // ---------------- button decisions and result push ----------------
    logic                         rel_go;
    logic                         rel_click_ok;
    logic                         rel_dbl;
    logic                         push_en;
    t_event_kind                  push_kind;
    logic signed [DELTA_BITS-1:0] push_val;
    logic [1:0]                   n_count;

    assign rel_go       = !r_pressed && r_was_down;
    assign rel_click_ok = r_min_ge && !r_hold_ge;
    assign rel_dbl      = rel_click_ok && r_awaiting && r_dbl_lt;

    always_comb begin
        push_en   = 1'b0;
        push_kind = EV_SPEED;
        push_val  = EV_VAL_ZERO;
        case (r_state)
            S_GUARD: begin
                push_en  = (r_pending != '0) && cmp_ge && r_bounce_ok;
                push_val = r_pending;
            end
            S_HOLD: begin
                push_en   = r_pressed && r_was_down && !r_hold_fired && cmp_ge;
                push_kind = EV_HOLD;
                push_val  = EV_VAL_ONE;
            end
            S_REL: begin
                if (rel_go && r_hold_fired) begin
                    push_en   = 1'b1;
                    push_kind = EV_HOLD_RELEASE;
                end else if (rel_go && rel_dbl) begin
                    push_en   = 1'b1;
                    push_kind = EV_DOUBLE_CLICK;
                    push_val  = EV_VAL_ONE;
                end
            end
            S_CLICK: begin
                push_en   = r_awaiting && cmp_ge;
                push_kind = EV_CLICK;
                push_val  = EV_VAL_ONE;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    assign n_count = r_n + {1'b0, push_en};

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpd          <= CPD_RST;
            r_poll_ms      <= POLL_RST;
            r_cw           <= CW_RST;
            r_bounce_ms    <= BOUNCE_RST;
            r_guard_ms     <= GUARD_RST;
            r_hold_ms      <= HOLD_RST;
            r_dbl_ms       <= DBL_RST;
            r_min_click_ms <= MIN_CLICK_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COUNTS_PER_DETENT: r_cpd          <= i_cfg_wdata[CPD_BITS-1:0];
                CFG_POLL_INTERVAL:     r_poll_ms      <= i_cfg_wdata[POLL_BITS-1:0];
                CFG_CLOCKWISE_INC:     r_cw           <= i_cfg_wdata[0];
                CFG_BOUNCE_FILTER:     r_bounce_ms    <= i_cfg_wdata[GAP_BITS-1:0];
                CFG_PRE_PRESS_GUARD:   r_guard_ms     <= i_cfg_wdata[GAP_BITS-1:0];
                CFG_HOLD_THRESHOLD:    r_hold_ms      <= i_cfg_wdata[GAP_BITS-1:0];
                CFG_DOUBLE_CLICK_WIN:  r_dbl_ms       <= i_cfg_wdata[GAP_BITS-1:0];
                CFG_MIN_CLICK:         r_min_click_ms <= i_cfg_wdata[GAP_BITS-1:0];
                default: begin
                    r_cpd <= r_cpd;
                end
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ready         <= 1'b0;
            r_prev_pos      <= '0;
            r_cnt_rem       <= '0;
            r_pending       <= '0;
            r_pending_since <= '0;
            r_last_poll     <= '0;
            r_last_button   <= '0;
            r_press_start   <= '0;
            r_first_click   <= '0;
            r_was_down      <= 1'b0;
            r_hold_fired    <= 1'b0;
            r_awaiting      <= 1'b0;
            r_n             <= '0;
            r_idx           <= 1'b0;
        end else begin
            if (push_en) begin
                r_ev_kind[r_n[0]] <= push_kind;
                r_ev_val[r_n[0]]  <= push_val;
                r_n               <= n_count;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_now     <= i_in.time_ms;
                        r_pos     <= i_in.raw_position;
                        r_pressed <= i_in.button_pressed;
                        if (i_in.kind == KIND_START) begin
                            r_prev_pos <= i_in.raw_position;
                            r_cnt_rem  <= '0;
                            r_ready    <= 1'b1;
                        end else if (r_ready) begin
                            r_state <= S_POLL;
                        end
                    end
                end
                S_POLL: begin
                    if (!cmp_ge) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last_poll <= r_now;
                        r_delta     <= r_pos - r_prev_pos;
                        r_prev_pos  <= r_pos;
                        r_n         <= '0;
                        r_state     <= S_BOUNCE;
                    end
                end
                S_BOUNCE: begin
                    r_bounce_ok <= cmp_gt;
                    r_state     <= (r_delta == '0) ? S_GUARD : S_DIV1;
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_q     <= q0_s;
                        r_rsum  <= rsum_new;
                        r_state <= S_DIV2S;
                    end
                end
                S_DIV2S: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_q     <= qs_new;
                        r_rs    <= rs_new;
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // pull the remainder to the sign of the quotient
                    if (q_pos && rs_neg) begin
                        r_q       <= r_q - Q_ONE;
                        r_cnt_rem <= REM_BITS'(rs_w + cpd_s);
                    end else if (q_neg && rs_pos) begin
                        r_q       <= r_q + Q_ONE;
                        r_cnt_rem <= REM_BITS'(rs_w - cpd_s);
                    end else begin
                        r_cnt_rem <= r_rs;
                    end
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_qf    <= r_cw ? qf : -qf;
                    r_state <= S_PEND;
                end
                S_PEND: begin
                    if ((r_qf != '0) && r_bounce_ok) begin
                        if (r_pending == '0) begin
                            r_pending_since <= r_now;
                        end
                        r_pending <= DELTA_BITS'(pend_sat);
                    end
                    r_state <= S_GUARD;
                end
                S_GUARD: begin
                    if (push_en) begin
                        r_pending <= '0;
                    end
                    r_state <= S_PRESS;
                end
                S_PRESS: begin
                    if (r_pressed && !r_was_down) begin
                        r_press_start <= r_now;
                        r_was_down    <= 1'b1;
                        r_hold_fired  <= 1'b0;
                        r_last_button <= r_now;
                        r_pending     <= '0;
                    end
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    r_hold_ge <= cmp_ge;
                    if (push_en) begin
                        r_hold_fired  <= 1'b1;
                        r_awaiting    <= 1'b0;
                        r_first_click <= '0;
                    end
                    r_state <= S_MINC;
                end
                S_MINC: begin
                    r_min_ge <= cmp_ge;
                    r_state  <= S_DBL;
                end
                S_DBL: begin
                    r_dbl_lt <= !cmp_ge;
                    r_state  <= S_REL;
                end
                S_REL: begin
                    if (rel_go) begin
                        r_was_down    <= 1'b0;
                        r_last_button <= r_now;
                        r_pending     <= '0;
                        if (!r_hold_fired && rel_click_ok) begin
                            if (rel_dbl) begin
                                r_awaiting    <= 1'b0;
                                r_first_click <= '0;
                            end else begin
                                r_awaiting    <= 1'b1;
                                r_first_click <= r_now;
                            end
                        end
                    end
                    r_state <= S_CLICK;
                end
                S_CLICK: begin
                    if (push_en) begin
                        r_awaiting    <= 1'b0;
                        r_first_click <= '0;
                    end
                    r_idx   <= 1'b0;
                    r_state <= (n_count != '0) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_fire) begin
                        if (out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_EMIT);
    assign o_out.event_kind  = r_ev_kind[r_idx];
    assign o_out.event_value = r_ev_val[r_idx];
    assign o_out.event_time  = r_now;
    assign o_out.last        = out_last;

endmodule
